// ----- src/nvc_pkg.sv -----
// package for the numeric value canonicaliser
// holds payload structs, kind and source codes; no dependencies
package nvc_pkg;

   typedef enum logic [1:0] {
      SRC_S64 = 2'd0,
      SRC_U64 = 2'd1,
      SRC_DBL = 2'd2,
      SRC_SGL = 2'd3
   } src_type;

   typedef enum logic [1:0] {
      KIND_S64  = 2'd0,
      KIND_U64  = 2'd1,
      KIND_DBL  = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [63:0] raw_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  canon_kind;
      logic [63:0] canon_bits;
   } rsp_type;

   localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
   localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;

endpackage

// ----- src/numeric_value_canonicalizer.sv -----
// numeric value canonicaliser top level
// three-stage pipeline, uses nvc_pkg
//
// usage: drive req_data with a source tag and a raw 64-bit pattern and pulse
// start. busy is always low, so a transaction is taken every cycle that
// start is high. each transaction gives exactly one result on rsp_data,
// marked by rsp_valid for one cycle; the result passes the three register
// stages in order, and rsp_valid is driven from the stage 3 register.
// throughput is one transaction per cycle.
// the three register stages:
// stage 1 widens single to double and decodes fields, stage 2 aligns the
// magnitude with a barrel shift and checks integrality, stage 3 negates and
// picks the kind. reset clears the valid bits only; results in flight are
// dropped. the receiver cannot stall, so nothing ever holds the pipeline.
module numeric_value_canonicalizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  nvc_pkg::req_type  req_data,
   output logic              rsp_valid,
   output nvc_pkg::rsp_type  rsp_data
);

   // stage 1
   logic        v1_ff, v1_in;
   logic [1:0]  cmd1_ff;
   logic [63:0] raw1_ff, dbl1_ff, dbl1_in;
   // stage 2
   logic        v2_ff;
   logic [1:0]  cmd2_ff;
   logic [63:0] raw2_ff, dbl2_ff, mag2_ff, mag2_in;
   logic        frac_lost2_ff, frac_lost2_in;
   logic [11:0] ex2_ff;
   // stage 3
   logic        v3_ff;
   nvc_pkg::rsp_type rsp3_ff, rsp3_in;

   logic [31:0] f;
   logic [7:0]  fe;
   logic [22:0] fm;
   logic [4:0]  lz;
   logic [22:0] fm_n;

   assign busy = 1'b0;
   assign v1_in = start;
   assign f  = req_data.raw_value[31:0];
   assign fe = f[30:23];
   assign fm = f[22:0];

   // leading-zero count of a subnormal single mantissa, and the normalised mantissa
   always_comb begin
      lz = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (fm[i]) lz = 5'(22 - i);
      end
      fm_n = fm << (lz + 5'd1);
   end

   always_comb begin
      dbl1_in = req_data.raw_value;
      if (req_data.cmd == nvc_pkg::SRC_SGL) begin
         if (fe == 8'hFF) begin
            dbl1_in = (fm != 23'd0) ?
               {f[31], 11'h7FF, 1'b1, fm[21:0], 29'd0} | {12'd0, fm, 29'd0} :
               {f[31], 11'h7FF, 52'd0};
         end else if (fe == 8'd0) begin
            if (fm == 23'd0)
               dbl1_in = {f[31], 63'd0};
            else
               dbl1_in = {f[31], 11'(11'd896 - 11'(lz)), fm_n, 29'd0};
         end else begin
            dbl1_in = {f[31], 11'({3'd0, fe} + 11'd896), fm, 29'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= v1_in;
      cmd1_ff <= req_data.cmd;
      raw1_ff <= req_data.raw_value;
      dbl1_ff <= dbl1_in;
   end

   // stage 2: align magnitude, check lost fraction bits
   logic [10:0] e1;
   logic [11:0] ex1;
   logic [63:0] m53;
   logic [5:0]  rsh;
   assign e1  = dbl1_ff[62:52];
   assign ex1 = 12'({1'b0, e1} - 12'd1023);
   assign m53 = {11'd0, 1'b1, dbl1_ff[51:0]};

   always_comb begin
      rsh = 6'(12'd52 - ex1);
      frac_lost2_in = 1'b0;
      if (!ex1[11] && ex1 <= 12'd52) begin
         mag2_in = m53 >> rsh;
         frac_lost2_in = ((m53 << (7'd64 - {1'b0, rsh})) != 64'd0) && (rsh != 6'd0);
      end else begin
         mag2_in = m53 << 6'(ex1 - 12'd52);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else       v2_ff <= v1_ff;
      cmd2_ff       <= cmd1_ff;
      raw2_ff       <= raw1_ff;
      dbl2_ff       <= dbl1_ff;
      mag2_ff       <= mag2_in;
      frac_lost2_ff <= frac_lost2_in;
      ex2_ff        <= ex1;
   end

   // stage 3: classify and negate
   logic [10:0] e2;
   logic [51:0] fr2;
   logic        neg2;
   assign e2   = dbl2_ff[62:52];
   assign fr2  = dbl2_ff[51:0];
   assign neg2 = dbl2_ff[63];

   always_comb begin
      rsp3_in.canon_kind = nvc_pkg::KIND_S64;
      rsp3_in.canon_bits = raw2_ff;
      unique case (cmd2_ff)
         nvc_pkg::SRC_S64: ;
         nvc_pkg::SRC_U64:
            rsp3_in.canon_kind = raw2_ff[63] ? nvc_pkg::KIND_U64 : nvc_pkg::KIND_S64;
         default: begin
            if (e2 == 11'h7FF) begin
               if (fr2 != 52'd0) begin
                  rsp3_in.canon_kind = nvc_pkg::KIND_NONE;
                  rsp3_in.canon_bits = 64'd0;
               end else begin
                  rsp3_in.canon_kind = nvc_pkg::KIND_DBL;
                  rsp3_in.canon_bits = dbl2_ff;
               end
            end else if (e2 == 11'd0 && fr2 == 52'd0) begin
               rsp3_in.canon_bits = 64'd0;
            end else if (e2 == 11'd0 || ex2_ff[11] || frac_lost2_ff ||
                         ex2_ff >= 12'd64 ||
                         (neg2 && ex2_ff == 12'd63 && fr2 != 52'd0)) begin
               rsp3_in.canon_kind = nvc_pkg::KIND_DBL;
               rsp3_in.canon_bits = (dbl2_ff == nvc_pkg::SIGN_BIT) ? 64'd0 : dbl2_ff;
            end else if (neg2) begin
               rsp3_in.canon_bits = 64'd0 - mag2_ff;
            end else if (ex2_ff == 12'd63) begin
               rsp3_in.canon_kind = nvc_pkg::KIND_U64;
               rsp3_in.canon_bits = mag2_ff;
            end else begin
               rsp3_in.canon_bits = mag2_ff;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= v2_ff;
      rsp3_ff <= rsp3_in;
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp3_ff;

endmodule
